>>> rtl/bpsu_pkg.sv
// Shared types, constants and helper functions of the BMP pixel stream unpacker.
// Used by every module in this folder; depends on nothing.
package bpsu_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
    localparam int unsigned DIM_W      = 13;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd6;

    localparam logic [2:0]  BPP_MIN     = 3'd2;
    localparam logic [2:0]  BPP_MAX     = 3'd4;
    localparam logic [2:0]  BPP_RESET   = 3'd3;
    localparam logic [31:0] RED_RESET   = 32'h00FF_0000;
    localparam logic [31:0] GREEN_RESET = 32'h0000_FF00;
    localparam logic [31:0] BLUE_RESET  = 32'h0000_00FF;
    localparam logic [31:0] ALPHA_RESET = 32'hFF00_0000;

    typedef struct packed {
        logic [1:0]       bpp_last;
        logic [COL_W-1:0] last_col;
        logic [ROW_W-1:0] last_row;
        logic [1:0]       pad;
        logic [31:0]      red_mask;
        logic [31:0]      green_mask;
        logic [31:0]      blue_mask;
        logic [31:0]      alpha_mask;
        logic [4:0]       red_shift;
        logic [4:0]       green_shift;
        logic [4:0]       blue_shift;
        logic [4:0]       alpha_shift;
    } t_cfg;

    typedef struct packed {
        logic [31:0] word;
        logic        row_end;
        logic        image_end;
    } t_pix;

    function automatic logic [4:0] trailing_zeros(input logic [31:0] mask);
        logic [4:0] sh;
        sh = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (mask[i]) begin
                sh = 5'(i);
            end
        end
        return sh;
    endfunction

    function automatic logic [7:0] extract_field(input logic [31:0] word,
                                                 input logic [31:0] mask,
                                                 input logic [4:0]  sh);
        logic [31:0] sel;
        sel = (word & mask) >> sh;
        return sel[7:0];
    endfunction

endpackage

>>> rtl/bpsu_cfg_regs.sv
// Configuration registers of the BMP pixel stream unpacker with range clamping.
// Also keeps the trailing-zero shift of each channel mask. Depends on bpsu_pkg.
module bpsu_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpsu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bpsu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bpsu_pkg::t_cfg                    o_cfg
);
    import bpsu_pkg::*;

    logic [2:0]       r_bpp;
    logic [COL_W-1:0] r_last_col;
    logic [ROW_W-1:0] r_last_row;
    logic [31:0]      r_red_mask, r_green_mask, r_blue_mask, r_alpha_mask;
    logic [4:0]       r_red_shift, r_green_shift, r_blue_shift, r_alpha_shift;

    logic [2:0]       n_bpp;
    logic [COL_W-1:0] n_last_col;
    logic [ROW_W-1:0] n_last_row;
    logic [4:0]       n_shift;
    logic [DIM_W-1:0] dim;
    logic [1:0]       width_lsb;
    logic [1:0]       row_bytes;

    always_comb begin
        dim = i_cfg_data[DIM_W-1:0];
        if (i_cfg_data[2:0] < BPP_MIN) begin
            n_bpp = BPP_MIN;
        end else if (i_cfg_data[2:0] > BPP_MAX) begin
            n_bpp = BPP_MAX;
        end else begin
            n_bpp = i_cfg_data[2:0];
        end
        if (dim == '0) begin
            n_last_col = '0;
        end else if (dim > DIM_W'(MAX_WIDTH)) begin
            n_last_col = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_last_col = COL_W'(dim - DIM_W'(1));
        end
        if (dim == '0) begin
            n_last_row = '0;
        end else if (dim > DIM_W'(MAX_HEIGHT)) begin
            n_last_row = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            n_last_row = ROW_W'(dim - DIM_W'(1));
        end
        n_shift = trailing_zeros(i_cfg_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp         <= BPP_RESET;
            r_last_col    <= '0;
            r_last_row    <= '0;
            r_red_mask    <= RED_RESET;
            r_green_mask  <= GREEN_RESET;
            r_blue_mask   <= BLUE_RESET;
            r_alpha_mask  <= ALPHA_RESET;
            r_red_shift   <= 5'd16;
            r_green_shift <= 5'd8;
            r_blue_shift  <= 5'd0;
            r_alpha_shift <= 5'd24;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BPP: begin
                    r_bpp <= n_bpp;
                end
                CFG_WIDTH: begin
                    r_last_col <= n_last_col;
                end
                CFG_HEIGHT: begin
                    r_last_row <= n_last_row;
                end
                CFG_RED: begin
                    r_red_mask  <= i_cfg_data;
                    r_red_shift <= n_shift;
                end
                CFG_GREEN: begin
                    r_green_mask  <= i_cfg_data;
                    r_green_shift <= n_shift;
                end
                CFG_BLUE: begin
                    r_blue_mask  <= i_cfg_data;
                    r_blue_shift <= n_shift;
                end
                CFG_ALPHA: begin
                    r_alpha_mask  <= i_cfg_data;
                    r_alpha_shift <= n_shift;
                end
                default: begin
                end
            endcase
        end
    end

    // Row padding is the two's complement of the row byte count modulo four.
    assign width_lsb = 2'(r_last_col[1:0] + 2'd1);
    assign row_bytes = 2'(width_lsb * r_bpp[1:0]);

    always_comb begin
        o_cfg             = '0;
        o_cfg.bpp_last    = 2'(r_bpp - 3'd1);
        o_cfg.last_col    = r_last_col;
        o_cfg.last_row    = r_last_row;
        o_cfg.pad         = 2'(2'd0 - row_bytes);
        o_cfg.red_mask    = r_red_mask;
        o_cfg.green_mask  = r_green_mask;
        o_cfg.blue_mask   = r_blue_mask;
        o_cfg.alpha_mask  = r_alpha_mask;
        o_cfg.red_shift   = r_red_shift;
        o_cfg.green_shift = r_green_shift;
        o_cfg.blue_shift  = r_blue_shift;
        o_cfg.alpha_shift = r_alpha_shift;
    end

endmodule

>>> rtl/bpsu_assembler.sv
// Byte assembler of the BMP pixel stream unpacker: gathers pixel bytes, skips
// row padding, tracks column and row and registers each finished pixel word.
// Depends on bpsu_pkg.
module bpsu_assembler (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpsu_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_data_byte,
    output logic            o_pix_valid,
    input  logic            i_pix_ready,
    output bpsu_pkg::t_pix  o_pix
);
    import bpsu_pkg::*;

    logic [23:0]      r_acc;
    logic [1:0]       r_pos;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [1:0]       r_pad;
    logic             r_pix_valid;
    t_pix             r_pix;

    logic        fire;
    logic        pad_byte;
    logic        last_byte;
    logic        row_end;
    logic        image_end;
    logic [31:0] n_word;

    assign o_in_ready = !r_pix_valid || i_pix_ready;
    assign fire       = i_in_valid && o_in_ready;
    assign pad_byte   = (r_pad != 2'd0);
    assign last_byte  = !pad_byte && (r_pos >= i_cfg.bpp_last);
    assign row_end    = (r_col >= i_cfg.last_col);
    assign image_end  = row_end && (r_row >= i_cfg.last_row);
    assign n_word     = {8'd0, r_acc} | ({24'd0, i_data_byte} << {r_pos, 3'b000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pos       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_pad       <= '0;
            r_pix_valid <= 1'b0;
        end else begin
            if (fire && last_byte) begin
                r_pix_valid <= 1'b1;
            end else if (i_pix_ready) begin
                r_pix_valid <= 1'b0;
            end
            if (fire) begin
                if (pad_byte) begin
                    r_pad <= 2'(r_pad - 2'd1);
                end else if (!last_byte) begin
                    r_acc <= n_word[23:0];
                    r_pos <= 2'(r_pos + 2'd1);
                end else begin
                    r_acc <= '0;
                    r_pos <= '0;
                    if (row_end) begin
                        r_col <= '0;
                        r_pad <= i_cfg.pad;
                        r_row <= image_end ? '0 : ROW_W'(r_row + 1'b1);
                    end else begin
                        r_col <= COL_W'(r_col + 1'b1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && last_byte) begin
            r_pix.word      <= n_word;
            r_pix.row_end   <= row_end;
            r_pix.image_end <= image_end;
        end
    end

    assign o_pix_valid = r_pix_valid;
    assign o_pix       = r_pix;

    a_pad_after_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad != 2'd0 |-> r_pos == 2'd0)
        else $error("padding pending with a partial pixel");

    a_pixel_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && last_byte |=> r_pos == 2'd0 && r_acc == 24'd0 && r_pix_valid)
        else $error("finished pixel did not clear the assembler");

    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_valid && !i_pix_ready |=> r_pix_valid && $stable(r_pix))
        else $error("stalled pixel word lost or changed");

    a_image_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_valid |-> !r_pix.image_end || r_pix.row_end)
        else $error("image end without row end");

endmodule

>>> rtl/bpsu_extract.sv
// Channel extraction and output register of the BMP pixel stream unpacker.
// Masks and shifts each channel out of the pixel word. Depends on bpsu_pkg.
module bpsu_extract (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpsu_pkg::t_cfg  i_cfg,
    input  logic            i_pix_valid,
    output logic            o_pix_ready,
    input  bpsu_pkg::t_pix  i_pix,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_red_value,
    output logic [7:0]      o_green_value,
    output logic [7:0]      o_blue_value,
    output logic [7:0]      o_alpha_value,
    output logic            o_row_end,
    output logic            o_image_end
);
    import bpsu_pkg::*;

    logic       r_valid;
    logic [7:0] r_red, r_green, r_blue, r_alpha;
    logic       r_row_end, r_image_end;
    logic       load;

    assign o_pix_ready = !r_valid || i_out_ready;
    assign load        = i_pix_valid && o_pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pix_ready) begin
            r_valid <= i_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_red       <= extract_field(i_pix.word, i_cfg.red_mask, i_cfg.red_shift);
            r_green     <= extract_field(i_pix.word, i_cfg.green_mask, i_cfg.green_shift);
            r_blue      <= extract_field(i_pix.word, i_cfg.blue_mask, i_cfg.blue_shift);
            r_alpha     <= extract_field(i_pix.word, i_cfg.alpha_mask, i_cfg.alpha_shift);
            r_row_end   <= i_pix.row_end;
            r_image_end <= i_pix.image_end;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_red_value   = r_red;
    assign o_green_value = r_green;
    assign o_blue_value  = r_blue;
    assign o_alpha_value = r_alpha;
    assign o_row_end     = r_row_end;
    assign o_image_end   = r_image_end;

endmodule

>>> rtl/bmp_pixel_stream_unpacker.sv
// Top level of the BMP pixel stream unpacker.
// Instantiates bpsu_cfg_regs, bpsu_assembler and bpsu_extract; depends on bpsu_pkg.
//
// The input channel (i_in_valid, o_in_ready, i_data_byte) takes one byte of the
// BMP pixel array per request, rows in file order, row padding included. The
// output channel (o_out_valid, i_out_ready) delivers one request per pixel with
// the red, green, blue and alpha fields and the row-end and image-end flags.
// Padding bytes and the leading bytes of a pixel produce no output request.
// The configuration port writes register i_cfg_idx with i_cfg_data whenever
// i_cfg_we is high; it is meant to be used while the block is idle.
// One byte is accepted in every cycle while o_in_ready is high. After its last
// byte is accepted, a pixel passes through the pixel word register of the
// assembler and then the output register after channel extraction.
// When the receiver stalls, both registers fill and then o_in_ready drops; no
// request is lost and the input resumes at full rate once i_out_ready returns.
// Synchronous reset clears the counters, the partial pixel and both valid bits
// and loads the default configuration: 24-bit pixels, a one by one image and
// the standard red, green, blue and alpha masks.
module bmp_pixel_stream_unpacker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpsu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bpsu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_data_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_red_value,
    output logic [7:0]                        o_green_value,
    output logic [7:0]                        o_blue_value,
    output logic [7:0]                        o_alpha_value,
    output logic                              o_row_end,
    output logic                              o_image_end
);
    import bpsu_pkg::*;

    t_cfg cfg;
    t_pix pix;
    logic pix_valid;
    logic pix_ready;

    bpsu_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bpsu_assembler u_asm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .o_pix_valid (pix_valid),
        .i_pix_ready (pix_ready),
        .o_pix       (pix)
    );

    bpsu_extract u_ext (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_pix_valid   (pix_valid),
        .o_pix_ready   (pix_ready),
        .i_pix         (pix),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_red_value   (o_red_value),
        .o_green_value (o_green_value),
        .o_blue_value  (o_blue_value),
        .o_alpha_value (o_alpha_value),
        .o_row_end     (o_row_end),
        .o_image_end   (o_image_end)
    );

endmodule
